### rtl/nor_fork_one_instruction_cpu_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef NOR_FORK_ONE_INSTRUCTION_CPU_UNIT_MACROS_SVH
`define NOR_FORK_ONE_INSTRUCTION_CPU_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define NFOIC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define NFOIC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define NFOIC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nfoic_pkg.sv
package nfoic_pkg;

    localparam int MEM_DEPTH   = 65536;
    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int FETCH_BYTES = 8;
    localparam int CNT_W       = 3;

    localparam logic [15:0] IO_BASE   = 16'hC000;
    localparam logic [15:0] IO_END    = 16'hC008;
    localparam logic [15:0] WRITE_LOW = 16'h8000;
    localparam logic [15:0] BASE_MASK = 16'hFFF8;

    typedef enum logic [1:0] {
        CMD_EXEC = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WAIT,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_LOAD,
        ST_READ,
        ST_RCAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  nor_value;
        logic [7:0]  read_byte;
        logic        io_write_valid;
        logic [15:0] io_write_address;
        logic [7:0]  io_write_data;
        logic        debug_flag;
    } result_t;

endpackage

### rtl/nfoic_ram.sv
module nfoic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nfoic_seq.sv
module nfoic_seq import nfoic_pkg::*; #(
    parameter logic [15:0] DEBUG_OUT_ADDR = 16'hC000,
    parameter logic [15:0] DEBUG_IN_ADDR  = 16'hC001
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_command,
    input  logic [15:0] in_mem_address,
    input  logic [7:0]  in_mem_data,
    input  logic [63:0] in_io_read_bytes,
    output mem_req_t    mem_req,
    input  logic [7:0]  mem_rdata,
    output logic        res_valid,
    input  logic        res_free,
    output result_t     res
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0] pc_reg;
    logic        debug_reg;

    logic [15:0] maddr_reg;
    logic [7:0]  mdata_reg;
    logic [63:0] io_reg;
    logic [63:0] instr_reg;
    logic [7:0]  opa_reg;
    logic [7:0]  nor_reg;
    logic [7:0]  read_reg;
    logic        wv_reg;
    logic [15:0] wa_reg;
    logic [7:0]  wd_reg;

    logic [15:0] op_a, op_b, op_c, op_d;
    logic [7:0]  nor_now;
    logic        a_writable;
    logic        a_io_write;
    logic        accept;

    // Operand byte: peripheral window except the debug-in address reads memory.
    function automatic logic [7:0] pick_byte(input logic [15:0] addr, input logic [7:0] mbyte,
                                             input logic [63:0] io);
        logic [7:0] r;
        r = mbyte;
        if (addr >= IO_BASE && addr < IO_END && addr != DEBUG_IN_ADDR) begin
            r = io[{addr[2:0], 3'b000} +: 8];
        end
        return r;
    endfunction

    assign op_a = instr_reg[63:48];
    assign op_b = instr_reg[47:32];
    assign op_c = instr_reg[31:16];
    assign op_d = instr_reg[15:0];
    assign nor_now    = ~(opa_reg | pick_byte(op_b, mem_rdata, io_reg));
    assign a_writable = (op_a >= WRITE_LOW) && (op_a < IO_END);
    assign a_io_write = (op_a >= DEBUG_OUT_ADDR) && (op_a < IO_END);
    assign accept     = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (cmd_t'(in_command))
                        CMD_EXEC: state_next = ST_FETCH;
                        CMD_LOAD: state_next = ST_LOAD;
                        CMD_READ: state_next = ST_READ;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_FETCH: begin
                if (cnt_reg == CNT_W'(FETCH_BYTES - 1)) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_RD_A;
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_LOAD: state_next = ST_DONE;
            ST_READ: state_next = ST_RCAP;
            ST_RCAP: state_next = ST_DONE;
            ST_DONE: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = maddr_reg;
        mem_req.wdata = mdata_reg;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_FETCH: mem_req.addr = (pc_reg & BASE_MASK) | {13'd0, cnt_reg};
            ST_RD_A:  mem_req.addr = op_a;
            ST_RD_B:  mem_req.addr = op_b;
            ST_EXEC: begin
                mem_req.addr  = op_a;
                mem_req.wdata = nor_now;
                mem_req.we    = a_writable;
            end
            ST_LOAD:  mem_req.we = 1'b1;
            ST_DONE:  res_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pc_reg    <= '0;
            debug_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FETCH) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_EXEC) begin
                pc_reg <= (nor_now != 8'd0) ? op_c : op_d;
                if (op_a == DEBUG_OUT_ADDR) begin
                    debug_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            maddr_reg <= in_mem_address;
            mdata_reg <= in_mem_data;
            io_reg    <= in_io_read_bytes;
            nor_reg   <= '0;
            read_reg  <= '0;
            wv_reg    <= 1'b0;
            wa_reg    <= '0;
            wd_reg    <= '0;
        end
        // Shift in fetched bytes, first byte ends up on top.
        if ((state_reg == ST_FETCH && cnt_reg != '0) || state_reg == ST_WAIT) begin
            instr_reg <= {instr_reg[55:0], mem_rdata};
        end
        if (state_reg == ST_RD_B) begin
            opa_reg <= pick_byte(op_a, mem_rdata, io_reg);
        end
        if (state_reg == ST_EXEC) begin
            nor_reg <= nor_now;
            if (a_io_write) begin
                wv_reg <= 1'b1;
                wa_reg <= op_a;
                wd_reg <= nor_now;
            end
        end
        if (state_reg == ST_RCAP) begin
            read_reg <= mem_rdata;
        end
    end

    assign res.next_pc          = pc_reg;
    assign res.nor_value        = nor_reg;
    assign res.read_byte        = read_reg;
    assign res.io_write_valid   = wv_reg;
    assign res.io_write_address = wa_reg;
    assign res.io_write_data    = wd_reg;
    assign res.debug_flag       = debug_reg;

endmodule

### rtl/nor_fork_one_instruction_cpu_unit.sv
// NOR-and-branch one-instruction CPU with a 64 KiB byte memory.
// Input channel s_*: one request per handshake; s_tuser carries the command
// (execute, load byte, read byte), s_tdata the address, load byte and the
// peripheral read word. Result channel m_*: exactly one result per request;
// m_tuser flags a peripheral write, m_tdata carries pc, NOR, read byte,
// peripheral write address/data and the sticky debug flag.
// Rate: one request at a time, set by the single-port byte memory.
//   execute: fetch the instruction bytes, read operands A and B, write the
//            NOR back to A inside the writable window, then hand off the result
//   read: a memory read, load: a memory write, unused command: no memory access.
// The result lands in an output register; the next request is accepted
// while it still waits, and the sequencer holds in its done step only if a
// new result is ready before the receiver takes the old one.
// Reset clears pc, the debug flag and all handshake state; memory contents
// are undefined until loaded or written by an execute step.
// A stalled receiver (m_tready low) holds m_tvalid, m_tdata and m_tuser.
module nor_fork_one_instruction_cpu_unit import nfoic_pkg::*; #(
    parameter logic [15:0] DEBUG_OUT_ADDR = 16'hC000,
    parameter logic [15:0] DEBUG_IN_ADDR  = 16'hC001
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] mem_address, [23:16] mem_data, [87:24] io_read_bytes
    input  logic [87:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] next_pc, [23:16] nor_value, [31:24] read_byte,
    // [47:32] io_write_address, [55:48] io_write_data, [56] debug_flag, [63:57] zero
    output logic [63:0] m_tdata,
    // [0] io_write_valid
    output logic        m_tuser
);

    mem_req_t mem_req;
    logic [7:0] mem_rdata;
    result_t res;
    logic res_valid;
    logic res_free;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    nfoic_seq #(
        .DEBUG_OUT_ADDR(DEBUG_OUT_ADDR),
        .DEBUG_IN_ADDR (DEBUG_IN_ADDR)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_command      (s_tuser),
        .in_mem_address  (s_tdata[15:0]),
        .in_mem_data     (s_tdata[23:16]),
        .in_io_read_bytes(s_tdata[87:24]),
        .mem_req         (mem_req),
        .mem_rdata       (mem_rdata),
        .res_valid       (res_valid),
        .res_free        (res_free),
        .res             (res)
    );

    nfoic_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MEM_DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (mem_req.we),
        .addr (mem_req.addr),
        .wdata(mem_req.wdata),
        .rdata(mem_rdata)
    );

    // The output register is free when empty or drained this cycle.
    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load the result fields; hold them while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            m_tdata_reg <= {7'd0, res.debug_flag, res.io_write_data, res.io_write_address,
                            res.read_byte, res.nor_value, res.next_pc};
            m_tuser_reg <= res.io_write_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/nfoic_checker.sv
`include "nor_fork_one_instruction_cpu_unit_macros.svh"

module nfoic_checker #(
    parameter logic [15:0] DEBUG_OUT_ADDR = 16'hC000
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    `NFOIC_ASSERT_NXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid, "result valid after reset")

    `NFOIC_ASSERT_NXT(a_one_request, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    `NFOIC_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `NFOIC_ASSERT_IMP(a_io_window, aclk, aresetn, m_tvalid && m_tuser, m_tdata[47:32] >= DEBUG_OUT_ADDR && m_tdata[47:32] <= 16'hC007, "io write outside window")

    `NFOIC_ASSERT_IMP(a_io_quiet, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[55:32] == 24'd0 && m_tdata[63:57] == 7'd0, "io fields set without io write")

endmodule

bind nor_fork_one_instruction_cpu_unit nfoic_checker #(
    .DEBUG_OUT_ADDR(DEBUG_OUT_ADDR)
) u_nfoic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

### dv/tb_top.sv
module tb_top;
    import nfoic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Peripheral addresses handed to the block; the predictor uses the same values.
    localparam logic [15:0] DBG_OUT = 16'hC000;
    localparam logic [15:0] DBG_IN  = 16'hC001;

    // Two copies of the CPU state: the planning copy steers stimulus away from
    // never-written memory, the checking copy advances on each accepted request.
    localparam int PLAN_SIDE  = 0;
    localparam int CHECK_SIDE = 1;

    localparam int ITEM_GOAL   = 1250;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_PRINTS  = 40;

    localparam logic [15:0] EDGE_ADDR [8] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
                                             16'hBFFF, 16'hC000, 16'hC007, 16'hC008};

    typedef struct {
        cmd_t        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [63:0] io;
        bit          quiet;   // no idle cycles around this request
        bit          drain;   // hold this request until every result is back
    } request_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    // CPU state images, indexed by side
    logic [7:0]  mem_img     [2][65536];
    bit          written_img [2][65536];
    logic [15:0] pc_img      [2];
    bit          dbg_img     [2];

    request_t    request_q[$];
    result_t     pending_results[$];
    logic [15:0] data_pool[$];
    logic [15:0] prog_slots[$];

    request_t    cur_req;
    bit          plan_quiet;
    bit          drain_next;
    bit          rx_quiet;
    int          n_planned;
    int          accepted_cnt;
    int          done_cnt;
    int          err_cnt;
    int          tx_gap;
    int          rx_gap;
    int          hold_left;
    bit          hold_done;
    int          n_cmd [4];
    int          n_io_writes;
    int          n_zero_branch;

    nor_fork_one_instruction_cpu_unit #(
        .DEBUG_OUT_ADDR(DBG_OUT),
        .DEBUG_IN_ADDR (DBG_IN)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // CPU predictor
    // ------------------------------------------------------------------
    function automatic bit in_io_window(logic [15:0] x);
        return x >= IO_BASE && x < IO_END && x != DBG_IN;
    endfunction

    function automatic logic [15:0] word_at(int side, logic [15:0] x);
        return {mem_img[side][x], mem_img[side][x + 16'd1]};
    endfunction

    function automatic logic [7:0] operand_byte(int side, logic [15:0] x, logic [63:0] io);
        if (in_io_window(x)) begin
            return io[8 * (x - IO_BASE) +: 8];
        end
        return mem_img[side][x];
    endfunction

    // Apply one request to one state image and return the result it causes.
    function automatic result_t nor_cpu_step(int side, request_t r);
        logic [15:0] base;
        logic [15:0] op_a;
        logic [15:0] op_b;
        logic [15:0] op_c;
        logic [15:0] op_d;
        logic [7:0]  nor_v;
        result_t     res;
        res = '0;
        case (r.cmd)
            CMD_EXEC: begin
                base  = pc_img[side] & BASE_MASK;
                op_a  = word_at(side, base);
                op_b  = word_at(side, base + 16'd2);
                op_c  = word_at(side, base + 16'd4);
                op_d  = word_at(side, base + 16'd6);
                nor_v = ~(operand_byte(side, op_a, r.io) | operand_byte(side, op_b, r.io));
                // Write back only inside the writable window; report peripheral writes.
                if (op_a >= WRITE_LOW && op_a < IO_END) begin
                    mem_img[side][op_a]     = nor_v;
                    written_img[side][op_a] = 1'b1;
                    if (op_a >= DBG_OUT) begin
                        if (op_a == DBG_OUT) dbg_img[side] = 1'b1;
                        res.io_write_valid   = 1'b1;
                        res.io_write_address = op_a;
                        res.io_write_data    = nor_v;
                    end
                end
                pc_img[side]  = (nor_v != 8'd0) ? op_c : op_d;
                res.nor_value = nor_v;
            end
            CMD_LOAD: begin
                mem_img[side][r.addr]     = r.data;
                written_img[side][r.addr] = 1'b1;
            end
            CMD_READ: begin
                res.read_byte = mem_img[side][r.addr];
            end
            default: begin
            end
        endcase
        res.next_pc    = pc_img[side];
        res.debug_flag = dbg_img[side];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request planning
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word64();
        return {$urandom(), $urandom()};
    endfunction

    // An operand is readable if a peripheral answers it or memory holds a byte there.
    function automatic bit operand_ok(logic [15:0] x);
        return in_io_window(x) || written_img[PLAN_SIDE][x];
    endfunction

    function automatic bit exec_safe();
        logic [15:0] base;
        base = pc_img[PLAN_SIDE] & BASE_MASK;
        for (int i = 0; i < FETCH_BYTES; i++) begin
            if (!written_img[PLAN_SIDE][base + 16'(i)]) return 1'b0;
        end
        return operand_ok(word_at(PLAN_SIDE, base)) &&
               operand_ok(word_at(PLAN_SIDE, base + 16'd2));
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_data_addr();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16'hFFFF));
            1:       return 16'($urandom_range(16'h8000, 16'hC007));
            2:       return EDGE_ADDR[$urandom_range(0, 7)];
            default: return IO_BASE + 16'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [15:0] pick_slot();
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'h7FF8;
                2:       return IO_BASE;
                default: return 16'hFFF8;
            endcase
        end
        return 16'($urandom_range(0, 16'hFFFF)) & BASE_MASK;
    endfunction

    function automatic logic [15:0] pick_operand();
        logic [15:0] x;
        if ($urandom_range(0, 3) == 0) begin
            x = IO_BASE + 16'($urandom_range(0, 7));
            if (operand_ok(x)) return x;
        end
        return data_pool[$urandom_range(0, data_pool.size() - 1)];
    endfunction

    // Any byte of a program slot; the block clears the low bits on fetch.
    function automatic logic [15:0] jump_target();
        return prog_slots[$urandom_range(0, prog_slots.size() - 1)] +
               16'($urandom_range(0, 7));
    endfunction

    task automatic send(cmd_t c, logic [15:0] a, logic [7:0] d, logic [63:0] io);
        request_t r;
        r.cmd   = c;
        r.addr  = a;
        r.data  = d;
        r.io    = io;
        r.quiet = plan_quiet;
        r.drain = drain_next;
        drain_next = 1'b0;
        request_q.push_back(r);
        void'(nor_cpu_step(PLAN_SIDE, r));
        n_planned++;
    endtask

    task automatic load_byte(logic [15:0] a, logic [7:0] d);
        send(CMD_LOAD, a, d, rand_word64());
    endtask

    task automatic read_at(logic [15:0] a);
        send(CMD_READ, a, 8'($urandom_range(0, 255)), rand_word64());
    endtask

    task automatic exec_step(logic [63:0] io);
        send(CMD_EXEC, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)), io);
    endtask

    // Store A, B, C, D big-endian in the eight bytes of one slot.
    task automatic load_instr(logic [15:0] base, logic [15:0] a, logic [15:0] b,
                              logic [15:0] c, logic [15:0] d);
        logic [63:0] w;
        w = {a, b, c, d};
        for (int i = 0; i < FETCH_BYTES; i++) begin
            load_byte(base + 16'(i), w[63 - 8 * i -: 8]);
        end
    endtask

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------
    task automatic flag_error(string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 done_cnt, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: predict on acceptance, then present the next request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit      slot_free;
        int      outstanding;
        result_t want;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            slot_free   = !s_tvalid || s_tready;
            outstanding = accepted_cnt - done_cnt;
            if (s_tvalid && s_tready) begin
                want = nor_cpu_step(CHECK_SIDE, cur_req);
                pending_results.push_back(want);
                n_cmd[cur_req.cmd]++;
                if (want.io_write_valid) n_io_writes++;
                if (cur_req.cmd == CMD_EXEC && want.nor_value == 8'd0) n_zero_branch++;
                accepted_cnt <= accepted_cnt + 1;
                rx_quiet     <= cur_req.quiet;
                outstanding++;
            end
            if (slot_free) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() > 0 &&
                             (!request_q[0].drain || outstanding == 0)) begin
                    cur_req  = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_req.io, cur_req.data, cur_req.addr};
                    s_tuser  <= cur_req.cmd;
                    tx_gap   = cur_req.quiet ? 0 : idle_len();
                end else begin
                    // drop valid while idling or draining
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus one long hold-off that backs the
    // block up until it stalls its request side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && done_cnt >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap   = rx_quiet ? 0 : idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            done_cnt <= done_cnt + 1;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result %0d arrived with no request outstanding",
                                     done_cnt));
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc",          m_tdata[15:0],       want.next_pc);
                check_field("nor_value",        16'(m_tdata[23:16]), 16'(want.nor_value));
                check_field("read_byte",        16'(m_tdata[31:24]), 16'(want.read_byte));
                check_field("io_write_valid",   16'(m_tuser),        16'(want.io_write_valid));
                check_field("io_write_address", m_tdata[47:32],      want.io_write_address);
                check_field("io_write_data",    16'(m_tdata[55:48]), 16'(want.io_write_data));
                check_field("debug_flag",       16'(m_tdata[56]),    16'(want.debug_flag));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int          r;
        logic [15:0] x;
        logic [63:0] io;

        // Directed: unused command from reset, then two hand-built steps that
        // hit the debug-out write, the debug-in memory read, a peripheral read
        // at both ends of the window, a zero NOR and the top memory slot.
        plan_quiet = 1'b1;
        send(CMD_NONE, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
             rand_word64());
        load_instr(16'h0000, DBG_OUT, DBG_IN, 16'hFFFF, 16'h0008);
        load_byte(DBG_IN, 8'h00);
        exec_step(64'h0);
        load_instr(16'hFFF8, 16'hC007, 16'hFFFF, 16'h0003, 16'h0005);
        exec_step('1);
        read_at(16'hC007);
        read_at(DBG_OUT);
        read_at(16'hFFFF);
        exec_step(rand_word64());

        // Random programs: seed data bytes, fill a few slots whose jumps stay
        // inside the program, then run it with some noise mixed in.
        while (n_planned < ITEM_GOAL) begin
            plan_quiet = ($urandom_range(0, 3) == 0);
            drain_next = ($urandom_range(0, 2) == 0);
            data_pool.delete();
            prog_slots.delete();
            repeat ($urandom_range(3, 8)) begin
                x = pick_data_addr();
                load_byte(x, pick_byte());
                data_pool.push_back(x);
            end
            repeat ($urandom_range(2, 5)) prog_slots.push_back(pick_slot());
            foreach (prog_slots[i]) begin
                load_instr(prog_slots[i], pick_operand(), pick_operand(),
                           jump_target(), jump_target());
            end
            repeat ($urandom_range(10, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    if ($urandom_range(0, 1) == 0) begin
                        read_at(data_pool[$urandom_range(0, data_pool.size() - 1)]);
                    end else begin
                        read_at(jump_target());
                    end
                end else if (r < 13) begin
                    load_byte(16'($urandom_range(0, 16'hFFFF)), pick_byte());
                end else if (r < 16) begin
                    send(CMD_NONE, 16'($urandom_range(0, 16'hFFFF)),
                         8'($urandom_range(0, 255)), rand_word64());
                end
                // Rewrite the current slot if the step would touch unwritten memory.
                if (!exec_safe()) begin
                    load_instr(pc_img[PLAN_SIDE] & BASE_MASK, pick_operand(), pick_operand(),
                               jump_target(), jump_target());
                end
                case ($urandom_range(0, 9))
                    0:       io = 64'h0;
                    1:       io = '1;
                    default: io = rand_word64();
                endcase
                exec_step(io);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (done_cnt != n_planned) @(posedge aclk);
        // watch for stray results after the last one
        repeat (50) @(posedge aclk);
        if (pending_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Run covered %0d requests: %0d execute, %0d load, %0d read, %0d unused",
                 accepted_cnt, n_cmd[CMD_EXEC], n_cmd[CMD_LOAD], n_cmd[CMD_READ],
                 n_cmd[CMD_NONE]);
        $display("  with %0d peripheral writes, %0d zero-NOR branches, %0d mismatches",
                 n_io_writes, n_zero_branch, err_cnt);
        if (err_cnt == 0) begin
            $display("nor_fork_one_instruction_cpu_unit test passed");
        end else begin
            $display("nor_fork_one_instruction_cpu_unit test failed");
        end
        $finish;
    end

    // Timeout, far beyond the slowest legal run
    initial begin
        #10ms;
        $display("nor_fork_one_instruction_cpu_unit test failed");
        $finish;
    end

endmodule
